// File: sv/alternating_bisection_grid_cells_core_macros.svh
// ----------------------------------------------------------------------------
// alternating_bisection_grid_cells_core_macros.svh
// Assertion shorthands for the grid partition core, sampled on clk with
// the active low rst_n as disable
// ----------------------------------------------------------------------------
`ifndef ALTERNATING_BISECTION_GRID_CELLS_CORE_MACROS_SVH
`define ALTERNATING_BISECTION_GRID_CELLS_CORE_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define ABGC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ABGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/abgc_pkg.sv
// ----------------------------------------------------------------------------
// abgc_pkg
// Shared types and constants of the alternating bisection grid partition core
// ----------------------------------------------------------------------------
package abgc_pkg;

  // coordinate format: Q16.16 signed
  localparam int COORD_WIDTH      = 32;
  localparam int MAX_LEVELS_DEF   = 6;
  localparam int LEVEL_REG_WIDTH  = 3;
  localparam int CELL_IDX_WIDTH   = 6;
  localparam int CFG_ADDR_WIDTH   = 3;
  localparam int CFG_DATA_WIDTH   = 32;

  // register index of level_count
  localparam int REG_LEVEL_COUNT  = 0;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // one input box
  typedef struct packed {
    coord_t box_min_x;
    coord_t box_max_x;
    coord_t box_min_y;
    coord_t box_max_y;
  } box_t;

  // one result cell
  typedef struct packed {
    logic [CELL_IDX_WIDTH-1:0] cell_index;
    coord_t                    cell_min_x;
    coord_t                    cell_max_x;
    coord_t                    cell_min_y;
    coord_t                    cell_max_y;
    logic                      last_cell;
  } cell_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_EMIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic                      load_in;
    logic                      reload;
    logic                      split;
    logic                      split_x;
    logic                      split_hi;
    logic                      emit;
    logic [CELL_IDX_WIDTH-1:0] emit_index;
    logic                      emit_last;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

// File: sv/abgc_regs.sv
// ----------------------------------------------------------------------------
// abgc_regs
// Configuration register file: level_count with saturation to MAX_LEVELS
// ----------------------------------------------------------------------------
module abgc_regs #(
  parameter int MAX_LEVELS = abgc_pkg::MAX_LEVELS_DEF,
  parameter int LVL_W      = $clog2(MAX_LEVELS + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [abgc_pkg::CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [abgc_pkg::CFG_DATA_WIDTH-1:0] pwdata,
  output logic [abgc_pkg::CFG_DATA_WIDTH-1:0] prdata,
  output logic                                pready,
  output logic [LVL_W-1:0]                    levels
);
  import abgc_pkg::*;

  localparam logic [LEVEL_REG_WIDTH-1:0] MAX_LVL_REG = LEVEL_REG_WIDTH'(MAX_LEVELS);

  logic [LEVEL_REG_WIDTH-1:0] level_count_r;
  logic [LEVEL_REG_WIDTH-1:0] level_count_nxt;
  logic                       sel_level;
  logic                       wr_en;

  // register decode on the word index
  assign sel_level = (32'(paddr >> 2) == REG_LEVEL_COUNT);
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  // write path
  always_comb begin
    level_count_nxt = level_count_r;
    if (wr_en && sel_level) begin
      level_count_nxt = pwdata[LEVEL_REG_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r <= '0;
    end else begin
      level_count_r <= level_count_nxt;
    end
  end

  // read path
  assign prdata = sel_level ? CFG_DATA_WIDTH'(level_count_r) : '0;

  // effective level count
  assign levels = (level_count_r > MAX_LVL_REG) ? LVL_W'(MAX_LEVELS)
                                                : LVL_W'(level_count_r);

endmodule

// File: sv/abgc_ctrl.sv
// ----------------------------------------------------------------------------
// abgc_ctrl
// Sequencer: walks cells in index order and, per cell, the bisection levels
// ----------------------------------------------------------------------------
module abgc_ctrl #(
  parameter int MAX_LEVELS = abgc_pkg::MAX_LEVELS_DEF,
  parameter int LVL_W      = $clog2(MAX_LEVELS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [LVL_W-1:0]     levels,
  input  abgc_pkg::dp_status_t status,
  output abgc_pkg::dp_cmd_t    cmd,
  output abgc_pkg::state_t     state
);
  import abgc_pkg::*;

  localparam int CNT_W = MAX_LEVELS + 1;

  state_t                state_r;
  state_t                state_nxt;
  logic [LVL_W-1:0]      levels_r;
  logic [LVL_W-1:0]      levels_nxt;
  logic [LVL_W-1:0]      lvl_r;
  logic [LVL_W-1:0]      lvl_nxt;
  logic [MAX_LEVELS-1:0] cell_r;
  logic [MAX_LEVELS-1:0] cell_nxt;
  logic [LVL_W-1:0]      bit_pos;
  logic [MAX_LEVELS-1:0] cell_shift;
  logic                  is_last;
  logic                  in_xfer;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign state    = state_r;

  // path bit of the current level, most significant bit first
  assign bit_pos    = levels_r - lvl_r - LVL_W'(1);
  assign cell_shift = cell_r >> bit_pos;
  assign is_last    = ({1'b0, cell_r} + CNT_W'(1)) == (CNT_W'(1) << levels_r);

  // state register and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      levels_r <= '0;
      lvl_r    <= '0;
      cell_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      levels_r <= levels_nxt;
      lvl_r    <= lvl_nxt;
      cell_r   <= cell_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    levels_nxt     = levels_r;
    lvl_nxt        = lvl_r;
    cell_nxt       = cell_r;
    cmd            = '0;
    cmd.split_x    = lvl_r[0];
    cmd.split_hi   = cell_shift[0];
    cmd.emit_index = CELL_IDX_WIDTH'(cell_r);
    cmd.emit_last  = is_last;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd.load_in = 1'b1;
          levels_nxt  = levels;
          lvl_nxt     = '0;
          cell_nxt    = '0;
          state_nxt   = (levels == '0) ? ST_EMIT : ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        lvl_nxt   = lvl_r + LVL_W'(1);
        if (lvl_r == levels_r - LVL_W'(1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit = 1'b1;
          if (is_last) begin
            state_nxt = ST_IDLE;
            cell_nxt  = '0;
          end else begin
            cmd.reload = 1'b1;
            cell_nxt   = cell_r + MAX_LEVELS'(1);
            lvl_nxt    = '0;
            state_nxt  = ST_SPLIT;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/abgc_dp.sv
// ----------------------------------------------------------------------------
// abgc_dp
// Datapath: held box, working box with a midpoint unit, output register
// ----------------------------------------------------------------------------
module abgc_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  abgc_pkg::box_t       in_data,
  input  abgc_pkg::dp_cmd_t    cmd,
  output abgc_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output abgc_pkg::cell_t      out_data
);
  import abgc_pkg::*;

  box_t    held_r;
  box_t    held_nxt;
  box_t    work_r;
  box_t    work_nxt;
  cell_t   out_r;
  cell_t   out_nxt;
  logic    out_valid_r;
  logic    out_valid_nxt;
  coord_t  mid_a;
  coord_t  mid_b;
  coord_t  mid;
  logic signed [COORD_WIDTH:0] mid_sum;

  // floor of the mean over a sum one bit wider than a coordinate
  assign mid_a   = cmd.split_x ? work_r.box_min_x : work_r.box_min_y;
  assign mid_b   = cmd.split_x ? work_r.box_max_x : work_r.box_max_y;
  assign mid_sum = {mid_a[COORD_WIDTH-1], mid_a} + {mid_b[COORD_WIDTH-1], mid_b};
  assign mid     = mid_sum[COORD_WIDTH:1];

  // box registers
  always_comb begin
    held_nxt = held_r;
    work_nxt = work_r;
    if (cmd.load_in) begin
      held_nxt = in_data;
      work_nxt = in_data;
    end else if (cmd.reload) begin
      work_nxt = held_r;
    end else if (cmd.split) begin
      if (cmd.split_x) begin
        if (cmd.split_hi) work_nxt.box_min_x = mid;
        else              work_nxt.box_max_x = mid;
      end else begin
        if (cmd.split_hi) work_nxt.box_min_y = mid;
        else              work_nxt.box_max_y = mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    work_r <= work_nxt;
  end

  // output register, freed by a transfer on the result side
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.emit) begin
      out_nxt.cell_index = cmd.emit_index;
      out_nxt.cell_min_x = work_r.box_min_x;
      out_nxt.cell_max_x = work_r.box_max_x;
      out_nxt.cell_min_y = work_r.box_min_y;
      out_nxt.cell_max_y = work_r.box_max_y;
      out_nxt.last_cell  = cmd.emit_last;
      out_valid_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign status.out_busy = out_valid_r && out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

endmodule

// File: sv/alternating_bisection_grid_cells_core.sv
// ----------------------------------------------------------------------------
// alternating_bisection_grid_cells_core
// Splits one box into 2^L grid cells by alternating y/x bisection
//
//   channel   direction   handshake          payload
//   in_       input       in_valid/in_stall  box_t  (four Q16.16 bounds)
//   out_      output      out_valid/out_stall cell_t (index, bounds, last)
//   cfg       input       APB psel/penable   level_count at byte address 0
//
// Each cell is bisected once per level through the single midpoint adder,
// then loaded into the output register; when L is zero the box itself is
// emitted as the only cell.
// A synchronous active low reset returns the sequencer to idle and empties
// the output register; level_count resets to zero.
// A stalled result holds the sequencer in its emit step; the next cell is
// worked out while the previous one waits.
// ----------------------------------------------------------------------------
`include "alternating_bisection_grid_cells_core_macros.svh"

module alternating_bisection_grid_cells_core #(
  parameter int MAX_LEVELS = abgc_pkg::MAX_LEVELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  abgc_pkg::box_t                      in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output abgc_pkg::cell_t                     out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [abgc_pkg::CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [abgc_pkg::CFG_DATA_WIDTH-1:0] pwdata,
  output logic [abgc_pkg::CFG_DATA_WIDTH-1:0] prdata,
  output logic                                pready
);
  import abgc_pkg::*;

  localparam int LVL_W = $clog2(MAX_LEVELS + 1);
  localparam int CNT_W = CELL_IDX_WIDTH + 1;

  logic [LVL_W-1:0] levels;
  dp_cmd_t          cmd;
  dp_status_t       status;
  state_t           state;

  // configuration registers
  abgc_regs #(
    .MAX_LEVELS (MAX_LEVELS),
    .LVL_W      (LVL_W)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .levels  (levels)
  );

  // sequencer
  abgc_ctrl #(
    .MAX_LEVELS (MAX_LEVELS),
    .LVL_W      (LVL_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .levels   (levels),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  // datapath
  abgc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // checks
  `ABGC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, state != ST_IDLE, "accepted box did not start a run")
  `ABGC_ASSERT_NEXT(a_run_continues, out_valid && !out_stall && !out_data.last_cell, in_stall || out_valid, "input taken in the middle of a run")
  `ABGC_ASSERT_NOW(a_last_index, out_valid && out_data.last_cell, (CNT_W'(out_data.cell_index) + CNT_W'(1)) == (CNT_W'(1) << levels), "last cell index does not match the level count")

endmodule
